[src/pst_pkg.sv]
package pst_pkg;

    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned LANES    = 3;
    localparam int unsigned QUOT_W   = 16;
    localparam int unsigned DIV_STEPS = QUOT_W;

    localparam logic [SAMPLE_W-1:0] FULL_ALPHA = 8'd255;

    localparam logic [COUNT_W-1:0] COUNT_NONE       = 3'd0;
    localparam logic [COUNT_W-1:0] COUNT_GRAY       = 3'd1;
    localparam logic [COUNT_W-1:0] COUNT_GRAY_ALPHA = 3'd2;
    localparam logic [COUNT_W-1:0] COUNT_RGB        = 3'd3;
    localparam logic [COUNT_W-1:0] COUNT_RESET      = 3'd4;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic [LANES-1:0][QUOT_W-1:0]   dq;
        logic [LANES-1:0][SAMPLE_W-1:0] rem;
        sample_t                        divisor;
        sample_t                        alpha;
    } stage_t;

endpackage

[src/pst_pix_if.sv]
interface pst_pix_if;
    import pst_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_zero;
    sample_t sample_one;
    sample_t sample_two;
    sample_t sample_three;

    modport source (
        output valid, sample_zero, sample_one, sample_two, sample_three,
        input  ready
    );
    modport sink (
        input  valid, sample_zero, sample_one, sample_two, sample_three,
        output ready
    );
endinterface

[src/pst_rgba_if.sv]
interface pst_rgba_if;
    import pst_pkg::*;

    logic    valid;
    logic    ready;
    sample_t red_out;
    sample_t green_out;
    sample_t blue_out;
    sample_t alpha_out;

    modport source (
        output valid, red_out, green_out, blue_out, alpha_out,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, alpha_out,
        output ready
    );
endinterface

[src/pst_cfg_if.sv]
interface pst_cfg_if;
    import pst_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

[src/pst_expand.sv]
module pst_expand (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [pst_pkg::COUNT_W-1:0] count,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  pst_pkg::sample_t          s0,
    input  pst_pkg::sample_t          s1,
    input  pst_pkg::sample_t          s2,
    input  pst_pkg::sample_t          s3,
    output logic                      out_valid,
    output pst_pkg::stage_t           out_data,
    input  logic                      out_ready
);
    import pst_pkg::*;

    logic                       valid_reg;
    stage_t                     data_reg;
    stage_t                     data_next;
    logic [LANES-1:0][SAMPLE_W-1:0] color;
    logic [LANES-1:0][SAMPLE_W-1:0] color_eff;
    sample_t                    alpha;
    sample_t                    divisor;
    logic                       advance;

    always_comb
    begin
        color = '0;
        alpha = FULL_ALPHA;
        unique case (count)
            COUNT_NONE:
            begin
                color = '0;
            end
            COUNT_GRAY:
            begin
                color = {s0, s0, s0};
            end
            COUNT_GRAY_ALPHA:
            begin
                color = {s0, s0, s0};
                alpha = s1;
            end
            COUNT_RGB:
            begin
                color = {s2, s1, s0};
            end
            default:
            begin
                color = {s2, s1, s0};
                alpha = s3;
            end
        endcase
    end

    // zero alpha: divide zero by full scale, which yields zero
    always_comb
    begin
        divisor   = (alpha == '0) ? FULL_ALPHA : alpha;
        color_eff = (alpha == '0) ? '0 : color;
        data_next         = '0;
        data_next.divisor = divisor;
        data_next.alpha   = alpha;
        for (int i = 0; i < LANES; i++)
        begin
            data_next.dq[i] = ({color_eff[i], 8'd0} - {8'd0, color_eff[i]})
                              + {9'd0, divisor[SAMPLE_W-1:1]};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign advance   = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[src/pst_div_cell.sv]
module pst_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pst_pkg::stage_t in_data,
    output logic            out_valid,
    output pst_pkg::stage_t out_data,
    input  logic            out_ready
);
    import pst_pkg::*;

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;
    logic [SAMPLE_W:0] trial;
    logic [SAMPLE_W:0] diff;
    logic              q_bit;
    logic              advance;

    // one restoring step per lane: shift in the next dividend bit, try subtract
    always_comb
    begin
        data_next = in_data;
        trial     = '0;
        diff      = '0;
        q_bit     = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            trial = {in_data.rem[i], in_data.dq[i][QUOT_W-1]};
            diff  = trial - {1'b0, in_data.divisor};
            q_bit = (trial >= {1'b0, in_data.divisor});
            data_next.rem[i] = q_bit ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            data_next.dq[i]  = {in_data.dq[i][QUOT_W-2:0], q_bit};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign advance   = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.rem[0] < data_reg.divisor)
                   && (data_reg.rem[1] < data_reg.divisor)
                   && (data_reg.rem[2] < data_reg.divisor))
        else $error("remainder not below divisor");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.divisor != '0))
        else $error("zero divisor in cell");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled cell lost its request");
`endif

endmodule

[src/pixel_to_straight_rgba_top.sv]
// An accepted request is registered in the expand stage, then in each divider cell.
// Throughput: one pixel per cycle while dst is ready; one expand stage feeds
// 16 divider cells, each resolving one quotient bit for the three colors.
// Ready ripples back through the cells, so bubbles fill under stall.
// Reset clears all valid bits and sets count_reg to 4.
module pixel_to_straight_rgba_top (
    input  logic        clk,
    input  logic        rst_n,
    pst_cfg_if.sink     cfg,
    pst_pix_if.sink     src,
    pst_rgba_if.source  dst
);
    import pst_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic               valid_chain [0:DIV_STEPS];
    logic               ready_chain [0:DIV_STEPS];
    stage_t             data_chain  [0:DIV_STEPS];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg.valid)
        begin
            count_reg <= cfg.data;
        end
    end

    pst_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .count     (count_reg),
        .in_valid  (src.valid),
        .in_ready  (src.ready),
        .s0        (src.sample_zero),
        .s1        (src.sample_one),
        .s2        (src.sample_two),
        .s3        (src.sample_three),
        .out_valid (valid_chain[0]),
        .out_data  (data_chain[0]),
        .out_ready (ready_chain[0])
    );

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_cell
        pst_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_chain[k]),
            .in_ready  (ready_chain[k]),
            .in_data   (data_chain[k]),
            .out_valid (valid_chain[k+1]),
            .out_data  (data_chain[k+1]),
            .out_ready (ready_chain[k+1])
        );
    end

    assign dst.valid           = valid_chain[DIV_STEPS];
    assign ready_chain[DIV_STEPS] = dst.ready;
    assign dst.red_out   = data_chain[DIV_STEPS].dq[0][SAMPLE_W-1:0];
    assign dst.green_out = data_chain[DIV_STEPS].dq[1][SAMPLE_W-1:0];
    assign dst.blue_out  = data_chain[DIV_STEPS].dq[2][SAMPLE_W-1:0];
    assign dst.alpha_out = data_chain[DIV_STEPS].alpha;

endmodule

[bench/pst_checker.sv]
module pst_checker (
    input  logic        clk,
    input  logic        rst_n,
    pst_cfg_if          cfg,
    pst_pix_if          src,
    pst_rgba_if         dst,
    output int unsigned fail_count,
    output int unsigned pending
);
    import pst_pkg::*;

    typedef struct packed {
        sample_t red;
        sample_t green;
        sample_t blue;
        sample_t alpha;
    } rgba_t;

    logic [COUNT_W-1:0] comp_count;
    rgba_t              straight_queue[$];

    function automatic sample_t unpremultiply(sample_t c, sample_t a);
        int unsigned q;
        q = (32'(c) * 32'(FULL_ALPHA) + 32'(a >> 1)) / 32'(a);
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic rgba_t straighten(logic [COUNT_W-1:0] n, sample_t s0, sample_t s1,
                                         sample_t s2, sample_t s3);
        rgba_t p;
        p = '{red: '0, green: '0, blue: '0, alpha: FULL_ALPHA};
        case (n)
            COUNT_NONE: ;
            COUNT_GRAY:
            begin
                p.red   = s0;
                p.green = s0;
                p.blue  = s0;
            end
            COUNT_GRAY_ALPHA:
            begin
                p.red   = s0;
                p.green = s0;
                p.blue  = s0;
                p.alpha = s1;
            end
            COUNT_RGB:
            begin
                p.red   = s0;
                p.green = s1;
                p.blue  = s2;
            end
            default:
            begin
                p.red   = s0;
                p.green = s1;
                p.blue  = s2;
                p.alpha = s3;
            end
        endcase
        if (p.alpha == '0)
        begin
            p.red   = '0;
            p.green = '0;
            p.blue  = '0;
        end
        else if (p.alpha != FULL_ALPHA)
        begin
            p.red   = unpremultiply(p.red, p.alpha);
            p.green = unpremultiply(p.green, p.alpha);
            p.blue  = unpremultiply(p.blue, p.alpha);
        end
        return p;
    endfunction

    function automatic int compare_channel(string name, sample_t want, sample_t got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rgba_t want;
        int    errs;
        if (!rst_n)
        begin
            comp_count <= COUNT_RESET;
            straight_queue.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg.valid && cfg.ready)
                comp_count <= cfg.data;
            if (src.valid && src.ready)
                straight_queue.push_back(straighten(comp_count, src.sample_zero,
                    src.sample_one, src.sample_two, src.sample_three));
            if (dst.valid && dst.ready)
            begin
                if (straight_queue.size() == 0)
                begin
                    $display("%0t: unexpected pixel, expected none, actual %0d %0d %0d %0d",
                             $time, dst.red_out, dst.green_out, dst.blue_out, dst.alpha_out);
                    errs = 1;
                end
                else
                begin
                    want = straight_queue.pop_front();
                    errs += compare_channel("red", want.red, dst.red_out);
                    errs += compare_channel("green", want.green, dst.green_out);
                    errs += compare_channel("blue", want.blue, dst.blue_out);
                    errs += compare_channel("alpha", want.alpha, dst.alpha_out);
                end
            end
            fail_count <= fail_count + errs;
            pending    <= straight_queue.size();
        end
    end

endmodule

[bench/tb_pixel_to_straight_rgba_top.sv]
module tb_pixel_to_straight_rgba_top;
    import pst_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_PIXELS = 55;
    localparam int unsigned DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        sample_t            s0;
        sample_t            s1;
        sample_t            s2;
        sample_t            s3;
    } probe_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        throttle;
    int unsigned cycles = 0;
    int unsigned fail_count;
    int unsigned pending;

    pst_cfg_if  cfg_ch();
    pst_pix_if  pix_ch();
    pst_rgba_if rgba_ch();

    pixel_to_straight_rgba_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .src   (pix_ch),
        .dst   (rgba_ch)
    );

    pst_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .src        (pix_ch),
        .dst        (rgba_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    localparam probe_t PROBES[20] = '{
        '{COUNT_RESET, 8'd0, 8'd0, 8'd0, 8'd0},
        '{COUNT_RESET, 8'd255, 8'd255, 8'd255, 8'd255},
        '{COUNT_RESET, 8'd200, 8'd100, 8'd50, 8'd0},
        '{COUNT_RESET, 8'd255, 8'd128, 8'd1, 8'd1},
        '{COUNT_RESET, 8'd255, 8'd254, 8'd0, 8'd254},
        '{COUNT_RESET, 8'd10, 8'd20, 8'd30, 8'd128},
        '{COUNT_RESET, 8'd255, 8'd0, 8'd255, 8'd2},
        '{COUNT_GRAY_ALPHA, 8'd255, 8'd1, 8'd0, 8'd0},
        '{COUNT_GRAY_ALPHA, 8'd0, 8'd0, 8'd255, 8'd255},
        '{COUNT_GRAY_ALPHA, 8'd100, 8'd255, 8'd7, 8'd9},
        '{COUNT_GRAY_ALPHA, 8'd77, 8'd128, 8'd200, 8'd3},
        '{COUNT_GRAY, 8'd0, 8'd255, 8'd255, 8'd0},
        '{COUNT_GRAY, 8'd255, 8'd0, 8'd0, 8'd0},
        '{COUNT_RGB, 8'd255, 8'd0, 8'd128, 8'd0},
        '{COUNT_RGB, 8'd0, 8'd255, 8'd1, 8'd7},
        '{COUNT_NONE, 8'd255, 8'd255, 8'd255, 8'd128},
        '{3'd5, 8'd9, 8'd8, 8'd7, 8'd6},
        '{3'd7, 8'd200, 8'd150, 8'd100, 8'd100},
        '{3'd6, 8'd1, 8'd2, 8'd3, 8'd0},
        '{COUNT_GRAY_ALPHA, 8'd128, 8'd254, 8'd0, 8'd0}
    };

    localparam logic [COUNT_W-1:0] PHASE_COUNTS[12] = '{
        COUNT_RESET, COUNT_GRAY_ALPHA, COUNT_RGB, COUNT_GRAY, COUNT_NONE, 3'd7,
        3'd5, COUNT_GRAY_ALPHA, 3'd6, COUNT_RESET, COUNT_RGB, COUNT_RESET
    };

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_pixel(input probe_t p);
        if (throttle && $urandom_range(0, 4) == 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        pix_ch.valid        <= 1'b1;
        pix_ch.sample_zero  <= p.s0;
        pix_ch.sample_one   <= p.s1;
        pix_ch.sample_two   <= p.s2;
        pix_ch.sample_three <= p.s3;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
    endtask

    task automatic drain_pixels();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] n);
        drain_pixels();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= n;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic sample_t pick_color(sample_t alpha, bit well_formed);
        return well_formed ? sample_t'($urandom_range(0, alpha)) : sample_t'($urandom());
    endfunction

    function automatic probe_t random_pixel(logic [COUNT_W-1:0] n);
        probe_t  p;
        sample_t alpha;
        bit      well_formed;
        case ($urandom_range(0, 9))
            0:       alpha = 8'd0;
            1:       alpha = FULL_ALPHA;
            2:       alpha = 8'd1;
            3:       alpha = 8'd254;
            default: alpha = sample_t'($urandom());
        endcase
        well_formed = $urandom_range(0, 3) != 0;
        p = '{count: n, s0: sample_t'($urandom()), s1: sample_t'($urandom()),
              s2: sample_t'($urandom()), s3: sample_t'($urandom())};
        if (n == COUNT_GRAY_ALPHA)
        begin
            p.s0 = pick_color(alpha, well_formed);
            p.s1 = alpha;
        end
        else if (n >= COUNT_RESET)
        begin
            p.s0 = pick_color(alpha, well_formed);
            p.s1 = pick_color(alpha, well_formed);
            p.s2 = pick_color(alpha, well_formed);
            p.s3 = alpha;
        end
        return p;
    endfunction

    initial
    begin
        rgba_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (throttle && $urandom_range(0, 2) == 0)
            begin
                rgba_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            rgba_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        logic [COUNT_W-1:0] current;
        rst_n               = 1'b0;
        throttle            = 1'b1;
        pix_ch.valid        = 1'b0;
        pix_ch.sample_zero  = '0;
        pix_ch.sample_one   = '0;
        pix_ch.sample_two   = '0;
        pix_ch.sample_three = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        current = COUNT_RESET;
        write_count(current);
        foreach (PROBES[i])
        begin
            if (PROBES[i].count != current)
            begin
                current = PROBES[i].count;
                write_count(current);
            end
            push_pixel(PROBES[i]);
        end

        foreach (PHASE_COUNTS[p])
        begin
            write_count(PHASE_COUNTS[p]);
            throttle = !(p == 5 || p == $size(PHASE_COUNTS) - 1);
            repeat (PHASE_PIXELS) push_pixel(random_pixel(PHASE_COUNTS[p]));
        end

        drain_pixels();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
src/pst_pkg.sv
src/pst_pix_if.sv
src/pst_rgba_if.sv
src/pst_cfg_if.sv
src/pst_expand.sv
src/pst_div_cell.sv
src/pixel_to_straight_rgba_top.sv
bench/pst_checker.sv
bench/tb_pixel_to_straight_rgba_top.sv
